// ----- design/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants of the console line editor
// Character codes, the command passed from front to back, and the erase
// sequencer phases.
// ----------------------------------------------------------------------------
package cle_pkg;

  parameter int unsigned LineDepthDefault = 256;
  parameter int unsigned CmdFifoDepth     = 4;

  localparam int unsigned CfgWidth = 9;
  localparam logic [CfgWidth-1:0] MaxLenReset = 9'd256;

  localparam logic [7:0] ChEot   = 8'd4;
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChDel   = 8'd127;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChSpace = 8'd32;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_EOT,
    CMD_ERASE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] ch;
    logic [7:0] pos;
    logic       done;
    logic [8:0] len;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SPACE,
    PH_LAST
  } phase_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       line_done;
    logic [8:0] line_length;
    logic       last;
  } result_t;

endpackage

// ----- design/cle_stream_if.sv -----
// ----------------------------------------------------------------------------
// cle_rx_if / cle_tx_if: valid/ready channels of the console line editor
// Received bytes come in on cle_rx_if; echo, store and line-end beats leave
// on cle_tx_if.
// ----------------------------------------------------------------------------
interface cle_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cle_tx_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       store_valid;
  logic [7:0] store_index;
  logic [7:0] store_byte;
  logic       line_done;
  logic [8:0] line_length;
  logic       last;

  modport source (output valid, output tx_valid, output tx_byte, output store_valid,
                  output store_index, output store_byte, output line_done,
                  output line_length, output last, input ready);
  modport sink (input valid, input tx_valid, input tx_byte, input store_valid,
                input store_index, input store_byte, input line_done,
                input line_length, input last, output ready);
endinterface

// ----- design/cle_front.sv -----
// ----------------------------------------------------------------------------
// cle_front: byte classifier and line state
// Accepts received bytes, keeps the character count, the swallow flag and
// the maximum line length, and issues one command per byte that has output.
// ----------------------------------------------------------------------------
module cle_front #(
  parameter int unsigned LINE_DEPTH = cle_pkg::LineDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  cle_rx_if.sink                         rx,
  input  logic                           cfg_write_en,
  input  logic [cle_pkg::CfgWidth-1:0]   cfg_write_data,
  input  logic                           fifo_full,
  output logic                           push,
  output cle_pkg::cmd_t                  cmd
);

  localparam int unsigned CW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned EW = (CW > cle_pkg::CfgWidth) ? CW : cle_pkg::CfgWidth;

  logic [CW-1:0]                char_count;
  logic [CW-1:0]                char_count_next;
  logic                         swallow;
  logic                         swallow_next;
  logic [cle_pkg::CfgWidth-1:0] max_len;

  logic          accept;
  logic [EW-1:0] eff_max;
  logic [EW-1:0] pos_w;
  logic [EW-1:0] next_w;

  assign rx.ready = !fifo_full;
  assign accept   = rx.valid && rx.ready;
  assign pos_w    = EW'(char_count);
  assign next_w   = pos_w + EW'(1);

  // saturate the configured maximum to 1..LINE_DEPTH
  always_comb begin
    eff_max = EW'(max_len);
    if (max_len == '0) begin
      eff_max = EW'(1);
    end
    if (eff_max > EW'(LINE_DEPTH)) begin
      eff_max = EW'(LINE_DEPTH);
    end
  end

  always_comb begin
    push            = 1'b0;
    cmd.kind        = cle_pkg::CMD_PUT;
    cmd.ch          = rx.rx_byte;
    cmd.pos         = pos_w[7:0];
    cmd.done        = 1'b0;
    cmd.len         = 9'd0;
    char_count_next = char_count;
    swallow_next    = swallow;
    if (accept) begin
      priority if (swallow) begin
        swallow_next = 1'b0;
      end else if (rx.rx_byte == cle_pkg::ChEot) begin
        push            = 1'b1;
        cmd.kind        = cle_pkg::CMD_EOT;
        cmd.done        = 1'b1;
        cmd.len         = pos_w[8:0];
        char_count_next = '0;
      end else if (rx.rx_byte == cle_pkg::ChBs || rx.rx_byte == cle_pkg::ChDel) begin
        if (char_count != '0) begin
          push            = 1'b1;
          cmd.kind        = cle_pkg::CMD_ERASE;
          char_count_next = char_count - CW'(1);
        end
      end else if (rx.rx_byte == cle_pkg::ChCr || rx.rx_byte == cle_pkg::ChLf) begin
        push            = 1'b1;
        cmd.ch          = cle_pkg::ChLf;
        cmd.done        = 1'b1;
        cmd.len         = next_w[8:0];
        char_count_next = '0;
        swallow_next    = (rx.rx_byte == cle_pkg::ChCr);
      end else begin
        push = 1'b1;
        if (next_w >= eff_max) begin
          cmd.done        = 1'b1;
          cmd.len         = next_w[8:0];
          char_count_next = '0;
        end else begin
          char_count_next = next_w[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
      swallow    <= 1'b0;
      max_len    <= cle_pkg::MaxLenReset;
    end else begin
      char_count <= char_count_next;
      swallow    <= swallow_next;
      if (cfg_write_en) begin
        max_len <= cfg_write_data;
      end
    end
  end

  a_count_in_line: assert property (@(posedge clk) disable iff (rst)
    EW'(char_count) < EW'(LINE_DEPTH))
    else $error("character count reached line depth");

  a_swallow_after_cr: assert property (@(posedge clk) disable iff (rst)
    $rose(swallow) |-> $past(accept && rx.rx_byte == cle_pkg::ChCr))
    else $error("swallow flag set without a carriage return");

endmodule

// ----- design/cle_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// cle_cmd_fifo: command queue between front and back
// Small register FIFO; the head entry is presented directly to the back.
// ----------------------------------------------------------------------------
module cle_cmd_fifo #(
  parameter int unsigned DEPTH = cle_pkg::CmdFifoDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cle_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output cle_pkg::cmd_t head_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  cle_pkg::cmd_t entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [NW-1:0] fill;

  assign full       = (fill == NW'(DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      fill <= fill + NW'(push) - NW'(pop);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into a full queue");

endmodule

// ----- design/cle_back.sv -----
// ----------------------------------------------------------------------------
// cle_back: result sequencer
// Expands each command into one or three result beats and holds them in an
// output register while the receiver stalls.
// ----------------------------------------------------------------------------
module cle_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  cle_pkg::cmd_t cmd,
  output logic          pop,
  cle_tx_if.source      tx
);

  cle_pkg::phase_t  phase;
  cle_pkg::phase_t  phase_next;
  cle_pkg::result_t beat;
  cle_pkg::result_t out_reg;
  logic             out_valid;
  logic             load;

  assign load = cmd_valid && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= cle_pkg::PH_FIRST;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    beat       = '0;
    beat.last  = 1'b1;
    phase_next = phase;
    pop        = 1'b0;
    unique case (cmd.kind)
      cle_pkg::CMD_PUT: begin
        beat.tx_valid    = 1'b1;
        beat.tx_byte     = cmd.ch;
        beat.store_valid = 1'b1;
        beat.store_index = cmd.pos;
        beat.store_byte  = cmd.ch;
        beat.line_done   = cmd.done;
        beat.line_length = cmd.done ? cmd.len : 9'd0;
        pop              = load;
      end
      cle_pkg::CMD_EOT: begin
        beat.line_done   = 1'b1;
        beat.line_length = cmd.len;
        pop              = load;
      end
      cle_pkg::CMD_ERASE: begin
        beat.tx_valid = 1'b1;
        beat.tx_byte  = (phase == cle_pkg::PH_SPACE) ? cle_pkg::ChSpace : cle_pkg::ChBs;
        beat.last     = (phase == cle_pkg::PH_LAST);
        if (load) begin
          unique case (phase)
            cle_pkg::PH_FIRST: phase_next = cle_pkg::PH_SPACE;
            cle_pkg::PH_SPACE: phase_next = cle_pkg::PH_LAST;
            cle_pkg::PH_LAST: begin
              phase_next = cle_pkg::PH_FIRST;
              pop        = 1'b1;
            end
            default: phase_next = cle_pkg::PH_FIRST;
          endcase
        end
      end
      default: pop = load;
    endcase
  end

  // output register: refill when empty or when the held beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_reg <= beat;
    end
  end

  assign tx.valid       = out_valid;
  assign tx.tx_valid    = out_reg.tx_valid;
  assign tx.tx_byte     = out_reg.tx_byte;
  assign tx.store_valid = out_reg.store_valid;
  assign tx.store_index = out_reg.store_index;
  assign tx.store_byte  = out_reg.store_byte;
  assign tx.line_done   = out_reg.line_done;
  assign tx.line_length = out_reg.line_length;
  assign tx.last        = out_reg.last;

  a_phase_only_in_erase: assert property (@(posedge clk) disable iff (rst)
    phase != cle_pkg::PH_FIRST |-> cmd_valid && cmd.kind == cle_pkg::CMD_ERASE)
    else $error("erase phase advanced without an erase command");

  a_inner_beat_is_echo: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.last |-> tx.tx_valid && !tx.store_valid && !tx.line_done)
    else $error("non-final beat is not a plain echo");

endmodule

// ----- design/console_line_editor_core.sv -----
// ----------------------------------------------------------------------------
// console_line_editor_core: canonical-mode line assembler for console bytes
// Turns received characters into echo, line-buffer store and line-end beats.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per beat (valid/ready). tx carries result
//   beats; each beat has echo, store and line-end fields, and last marks the
//   final beat caused by one received byte. Bytes with no result (the byte
//   after a carriage return, an erase on an empty line) yield no beat.
//   cfg_write_en/cfg_write_data set the maximum line length; write it only
//   while the block is idle. It saturates to 1..LINE_DEPTH.
// Timing:
//   The first beat for a byte passes through the command queue and then the
//   output register before it shows on tx. An ordinary byte, EOT, CR or LF
//   yields one beat of the output register; an erase yields three, one per
//   echoed character, and a queued command's beat loads as the held one is
//   taken. The front keeps accepting while a command queue of CMD_FIFO_DEPTH
//   entries has room.
// Reset:
//   rst clears the count, the swallow flag and the queue, sets the maximum
//   line length to 256. When tx stalls, the current beat holds, the queue
//   fills and then rx.ready drops.
// ----------------------------------------------------------------------------
module console_line_editor_core #(
  parameter int unsigned LINE_DEPTH     = cle_pkg::LineDepthDefault,
  parameter int unsigned CMD_FIFO_DEPTH = cle_pkg::CmdFifoDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  cle_rx_if.sink                       rx,
  cle_tx_if.source                     tx,
  input  logic                         cfg_write_en,
  input  logic [cle_pkg::CfgWidth-1:0] cfg_write_data
);

  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  cle_pkg::cmd_t push_cmd;
  cle_pkg::cmd_t head_cmd;

  cle_front #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .fifo_full      (full),
    .push           (push),
    .cmd            (push_cmd)
  );

  cle_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .pop       (pop),
    .tx        (tx)
  );

endmodule
